// File: src/eaa_pkg.sv
// Package: shared codes, payload structs and reset constants of the actuator arbiter.
`default_nettype none
package eaa_pkg;

	localparam int TIMEOUT_W = 16;

	// action codes
	localparam logic [1:0] ACT_REQUEST = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_TICK    = 2'd2;

	// actuator codes
	localparam logic [1:0] UNIT_NONE      = 2'd0;
	localparam logic [1:0] UNIT_SPRINKLER = 2'd1;
	localparam logic [1:0] UNIT_FAN       = 2'd2;
	localparam logic [1:0] UNIT_LIGHT     = 2'd3;

	// requester / owner codes
	localparam logic [1:0] SRC_NONE    = 2'd0;
	localparam logic [1:0] SRC_MANUAL  = 2'd1;
	localparam logic [1:0] SRC_TRIGGER = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_SPRINKLER_TIMEOUT = 2'd0;
	localparam logic [1:0] CFG_FAN_TIMEOUT       = 2'd1;
	localparam logic [1:0] CFG_LIGHT_TIMEOUT     = 2'd2;

	// timeout reset values
	localparam logic [TIMEOUT_W-1:0] SPRINKLER_TIMEOUT_RST = 16'd5000;
	localparam logic [TIMEOUT_W-1:0] FAN_TIMEOUT_RST       = 16'd3000;
	localparam logic [TIMEOUT_W-1:0] LIGHT_TIMEOUT_RST     = 16'd5000;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] target;
		logic       turn_on;
		logic [1:0] requester;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic       drive_sprinkler;
		logic       drive_fan;
		logic       drive_light;
		logic [1:0] owner_now;
		logic       expired;
	} res_t;

	typedef struct packed {
		logic [1:0] unit;
		logic [1:0] owner;
	} arb_state_t;

	typedef struct packed {
		logic [TIMEOUT_W-1:0] sprinkler;
		logic [TIMEOUT_W-1:0] fan;
		logic [TIMEOUT_W-1:0] light;
	} timeouts_t;

endpackage
`default_nettype wire

// File: src/eaa_ifs.sv
// Interfaces: request, result and configuration channels of the actuator arbiter.
`default_nettype none
interface eaa_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] target;
	logic       turn_on;
	logic [1:0] requester;

	modport source (output valid, action, target, turn_on, requester, input ready);
	modport sink   (input valid, action, target, turn_on, requester, output ready);
endinterface

interface eaa_res_if;
	logic       valid;
	logic       ready;
	logic       granted;
	logic       drive_sprinkler;
	logic       drive_fan;
	logic       drive_light;
	logic [1:0] owner_now;
	logic       expired;

	modport source (output valid, granted, drive_sprinkler, drive_fan, drive_light,
		owner_now, expired, input ready);
	modport sink   (input valid, granted, drive_sprinkler, drive_fan, drive_light,
		owner_now, expired, output ready);
endinterface

interface eaa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// File: src/eaa_step.sv
// Next-state and result logic for one request, release or tick beat.
`default_nettype none
module eaa_step #(
	parameter int TIMER_BITS = 16
) (
	input  eaa_pkg::req_t           req,
	input  eaa_pkg::arb_state_t     cur,
	input  logic [TIMER_BITS-1:0]   elapsed_cur,
	input  eaa_pkg::timeouts_t      timeouts,
	output eaa_pkg::arb_state_t     nxt,
	output logic [TIMER_BITS-1:0]   elapsed_nxt,
	output eaa_pkg::res_t           res
);

	localparam int CMP_W = (TIMER_BITS > eaa_pkg::TIMEOUT_W) ? TIMER_BITS : eaa_pkg::TIMEOUT_W;

	logic [eaa_pkg::TIMEOUT_W-1:0] limit;
	logic [TIMER_BITS-1:0]         elapsed_inc;
	logic                          granted;
	logic                          expired;

	always_comb begin
		unique case (cur.unit)
			eaa_pkg::UNIT_SPRINKLER: limit = timeouts.sprinkler;
			eaa_pkg::UNIT_FAN:       limit = timeouts.fan;
			eaa_pkg::UNIT_LIGHT:     limit = timeouts.light;
			default:                 limit = '0;
		endcase
	end

	// saturating increment
	assign elapsed_inc = (elapsed_cur != {TIMER_BITS{1'b1}})
		? elapsed_cur + TIMER_BITS'(1) : elapsed_cur;

	always_comb begin
		nxt         = cur;
		elapsed_nxt = elapsed_cur;
		granted     = 1'b0;
		expired     = 1'b0;
		unique case (req.action)
			eaa_pkg::ACT_REQUEST: begin
				if (!req.turn_on) begin
					if (cur.unit == req.target &&
						(cur.owner == req.requester || req.requester == eaa_pkg::SRC_MANUAL)) begin
						nxt         = '{unit: eaa_pkg::UNIT_NONE, owner: eaa_pkg::SRC_NONE};
						elapsed_nxt = '0;
						granted     = 1'b1;
					end
				end else if (req.requester == eaa_pkg::SRC_MANUAL) begin
					// manual on for no actuator drops everything
					if (req.target == eaa_pkg::UNIT_NONE) begin
						nxt = '{unit: eaa_pkg::UNIT_NONE, owner: eaa_pkg::SRC_NONE};
					end else begin
						nxt = '{unit: req.target, owner: eaa_pkg::SRC_MANUAL};
					end
					elapsed_nxt = '0;
					granted     = 1'b1;
				end else if (req.requester == eaa_pkg::SRC_TRIGGER) begin
					if (cur.unit == eaa_pkg::UNIT_NONE && req.target != eaa_pkg::UNIT_NONE) begin
						nxt         = '{unit: req.target, owner: eaa_pkg::SRC_TRIGGER};
						elapsed_nxt = '0;
						granted     = 1'b1;
					end
				end
			end
			eaa_pkg::ACT_RELEASE: begin
				nxt         = '{unit: eaa_pkg::UNIT_NONE, owner: eaa_pkg::SRC_NONE};
				elapsed_nxt = '0;
				granted     = 1'b1;
			end
			eaa_pkg::ACT_TICK: begin
				if (cur.unit != eaa_pkg::UNIT_NONE) begin
					if (limit != '0 && CMP_W'(elapsed_inc) >= CMP_W'(limit)) begin
						nxt         = '{unit: eaa_pkg::UNIT_NONE, owner: eaa_pkg::SRC_NONE};
						elapsed_nxt = '0;
						expired     = 1'b1;
					end else begin
						elapsed_nxt = elapsed_inc;
					end
				end
			end
			default: begin
				// unused action code: no change
			end
		endcase
	end

	assign res.granted         = granted;
	assign res.drive_sprinkler = (nxt.unit == eaa_pkg::UNIT_SPRINKLER);
	assign res.drive_fan       = (nxt.unit == eaa_pkg::UNIT_FAN);
	assign res.drive_light     = (nxt.unit == eaa_pkg::UNIT_LIGHT);
	assign res.owner_now       = nxt.owner;
	assign res.expired         = expired;

endmodule
`default_nettype wire

// File: src/exclusive_actuator_arbiter_core.sv
// Top level: exclusive actuator arbiter with input stage, state and result register.
// Path: a beat accepted on the request channel is loaded into the input register and then
//   into the result register, where it is held while the result sink stalls.
// Throughput: one beat per cycle when not stalled; the state update is a single short step.
// Reset (arst_n low): no actuator active, no owner, timer zero, timeouts back to
//   5000/3000/5000 ticks, both pipeline stages empty.
`default_nettype none
module exclusive_actuator_arbiter_core #(
	parameter int TIMER_BITS = 16
) (
	input  wire        clk,
	input  wire        arst_n,
	eaa_req_if.sink    req,
	eaa_res_if.source  res,
	eaa_cfg_if.sink    cfg
);

	// Input stage
	eaa_pkg::req_t req_s1;
	logic          valid_s1;

	// Arbiter state
	eaa_pkg::arb_state_t   state_q;
	logic [TIMER_BITS-1:0] elapsed_q;
	eaa_pkg::timeouts_t    timeouts_q;

	// Result register
	eaa_pkg::res_t res_q;
	logic          res_valid_q;

	// Step outputs
	eaa_pkg::arb_state_t   state_nxt;
	logic [TIMER_BITS-1:0] elapsed_nxt;
	eaa_pkg::res_t         res_nxt;

	logic advance;

	// Move the staged beat into the result register whenever that slot is free
	// or being drained this cycle; the input stage refills in the same cycle.
	assign advance   = !res_valid_q || res.ready;
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Payload of the input stage: no reset needed
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= '{action: req.action, target: req.target,
				turn_on: req.turn_on, requester: req.requester};
		end
	end

	eaa_step #(
		.TIMER_BITS (TIMER_BITS)
	) u_step (
		.req         (req_s1),
		.cur         (state_q),
		.elapsed_cur (elapsed_q),
		.timeouts    (timeouts_q),
		.nxt         (state_nxt),
		.elapsed_nxt (elapsed_nxt),
		.res         (res_nxt)
	);

	// Commit the state only when the beat actually leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '{unit: eaa_pkg::UNIT_NONE, owner: eaa_pkg::SRC_NONE};
			elapsed_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q   <= state_nxt;
			elapsed_q <= elapsed_nxt;
		end
	end

	// Timeout registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeouts_q <= '{sprinkler: eaa_pkg::SPRINKLER_TIMEOUT_RST,
				fan: eaa_pkg::FAN_TIMEOUT_RST, light: eaa_pkg::LIGHT_TIMEOUT_RST};
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				eaa_pkg::CFG_SPRINKLER_TIMEOUT: timeouts_q.sprinkler <= cfg.wdata;
				eaa_pkg::CFG_FAN_TIMEOUT:       timeouts_q.fan       <= cfg.wdata;
				eaa_pkg::CFG_LIGHT_TIMEOUT:     timeouts_q.light     <= cfg.wdata;
				default: begin
					// no register here: drop the write
				end
			endcase
		end
	end

	// Result register: hold while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.granted         = res_q.granted;
	assign res.drive_sprinkler = res_q.drive_sprinkler;
	assign res.drive_fan       = res_q.drive_fan;
	assign res.drive_light     = res_q.drive_light;
	assign res.owner_now       = res_q.owner_now;
	assign res.expired         = res_q.expired;

	// An idle arbiter never carries a running timer
	a_idle_timer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.unit == eaa_pkg::UNIT_NONE) |-> (elapsed_q == '0))
		else $error("timer nonzero with no active actuator");

	// Owner present exactly when some actuator is driven
	a_owner_matches_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> ((res_q.owner_now == eaa_pkg::SRC_NONE) ==
			!(res_q.drive_sprinkler || res_q.drive_fan || res_q.drive_light)))
		else $error("owner and drive outputs disagree");

	// A timeout shutoff is never a grant and leaves everything off
	a_expired_all_off: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.expired) |-> (!res_q.granted && !res_q.drive_sprinkler &&
			!res_q.drive_fan && !res_q.drive_light))
		else $error("expired result with grant or active drive");

	// State moves only when a staged beat advances
	a_state_only_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> ($stable(state_q) && $stable(elapsed_q)))
		else $error("arbiter state changed without a beat");

endmodule
`default_nettype wire

// File: tb/tb_exclusive_actuator_arbiter_core.sv
`timescale 1ns / 100ps
// Testbench: checks the exclusive actuator arbiter core beat by beat against its own predictor.
module tb_exclusive_actuator_arbiter_core;

	localparam int TIMER_BITS   = 16;
	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 7;
	localparam int IDLE_LIMIT   = 2000;   // well above the long receiver hold-off
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 4;      // two pipeline stages, taken twice over
	localparam int RAND_PHASES  = 5;
	localparam int RAND_ITEMS   = 175;
	localparam int MAX_PRINTS   = 40;

	// codes the package leaves unnamed but the fields can carry
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] SRC_UNUSED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic       DIR_OFF    = 1'b0;
	localparam logic       DIR_ON     = 1'b1;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          drv_valid = 1'b0;
	eaa_pkg::req_t drv_item  = '0;
	logic          drv_ready = 1'b0;
	logic          cfg_valid = 1'b0;
	logic [1:0]    cfg_index = eaa_pkg::CFG_SPRINKLER_TIMEOUT;
	logic [15:0]   cfg_wdata = '0;
	logic          req_took  = 1'b0;

	eaa_req_if req_ch ();
	eaa_res_if res_ch ();
	eaa_cfg_if cfg_ch ();

	// All block inputs come from testbench registers that start at known values.
	assign req_ch.valid     = drv_valid;
	assign req_ch.action    = drv_item.action;
	assign req_ch.target    = drv_item.target;
	assign req_ch.turn_on   = drv_item.turn_on;
	assign req_ch.requester = drv_item.requester;
	assign res_ch.ready     = drv_ready;
	assign cfg_ch.valid     = cfg_valid;
	assign cfg_ch.index     = cfg_index;
	assign cfg_ch.wdata     = cfg_wdata;

	exclusive_actuator_arbiter_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Predictor state: arbitration state and timeout registers as the block should hold them.
	logic [1:0]                    act_unit      = eaa_pkg::UNIT_NONE;
	logic [1:0]                    act_owner     = eaa_pkg::SRC_NONE;
	logic [TIMER_BITS-1:0]         elapsed       = '0;
	logic [eaa_pkg::TIMEOUT_W-1:0] tmo_sprinkler = eaa_pkg::SPRINKLER_TIMEOUT_RST;
	logic [eaa_pkg::TIMEOUT_W-1:0] tmo_fan       = eaa_pkg::FAN_TIMEOUT_RST;
	logic [eaa_pkg::TIMEOUT_W-1:0] tmo_light     = eaa_pkg::LIGHT_TIMEOUT_RST;

	eaa_pkg::req_t pending_q[$];        // request beats waiting for the driver
	eaa_pkg::res_t expected_res_q[$];   // predicted results, oldest first

	int n_issued      = 0;
	int n_accepted    = 0;
	int n_checked     = 0;
	int n_errors      = 0;
	int n_cfg         = 0;
	int n_expired     = 0;
	int n_granted     = 0;
	int idle_cycles   = 0;
	int hold_requests = 0;
	int holds_served  = 0;
	int hold_left     = 0;
	int burst_left    = 0;
	int gap_left      = 0;
	int pattern_cnt   = 0;
	int ready_mode    = 0;

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (got !== want)
			report($sformatf("result %0d %s: expected %0d, got %0d", n_checked, name, want, got));
	endtask

	task automatic clear_arbiter();
		act_unit  = eaa_pkg::UNIT_NONE;
		act_owner = eaa_pkg::SRC_NONE;
		elapsed   = '0;
	endtask

	// Advance the predicted state by one request beat and form its result.
	task automatic arbitrate(input eaa_pkg::req_t r, output eaa_pkg::res_t e);
		logic                          grant;
		logic                          expire;
		logic [eaa_pkg::TIMEOUT_W-1:0] lim;
		grant  = 1'b0;
		expire = 1'b0;
		case (r.action)
		eaa_pkg::ACT_REQUEST: begin
			if (r.turn_on == DIR_OFF) begin
				// off needs the active unit named, by its owner or by manual
				if (act_unit == r.target &&
						(act_owner == r.requester || r.requester == eaa_pkg::SRC_MANUAL)) begin
					clear_arbiter();
					grant = 1'b1;
				end
			end else if (r.requester == eaa_pkg::SRC_MANUAL) begin
				// manual always wins; manual on for no unit releases everything
				if (r.target == eaa_pkg::UNIT_NONE) begin
					clear_arbiter();
				end else begin
					act_unit  = r.target;
					act_owner = eaa_pkg::SRC_MANUAL;
					elapsed   = '0;
				end
				grant = 1'b1;
			end else if (r.requester == eaa_pkg::SRC_TRIGGER) begin
				if (act_unit == eaa_pkg::UNIT_NONE && r.target != eaa_pkg::UNIT_NONE) begin
					act_unit  = r.target;
					act_owner = eaa_pkg::SRC_TRIGGER;
					elapsed   = '0;
					grant     = 1'b1;
				end
			end
		end
		eaa_pkg::ACT_RELEASE: begin
			clear_arbiter();
			grant = 1'b1;
		end
		eaa_pkg::ACT_TICK: begin
			if (act_unit != eaa_pkg::UNIT_NONE) begin
				case (act_unit)
				eaa_pkg::UNIT_SPRINKLER: lim = tmo_sprinkler;
				eaa_pkg::UNIT_FAN:       lim = tmo_fan;
				default:                 lim = tmo_light;
				endcase
				// saturate, never wrap
				if (elapsed != {TIMER_BITS{1'b1}})
					elapsed = elapsed + 1'b1;
				if (lim != '0 && elapsed >= lim) begin
					clear_arbiter();
					expire = 1'b1;
				end
			end
		end
		default: ;
		endcase
		e.granted         = grant;
		e.drive_sprinkler = (act_unit == eaa_pkg::UNIT_SPRINKLER);
		e.drive_fan       = (act_unit == eaa_pkg::UNIT_FAN);
		e.drive_light     = (act_unit == eaa_pkg::UNIT_LIGHT);
		e.owner_now       = act_owner;
		e.expired         = expire;
	endtask

	function automatic eaa_pkg::req_t mk_req(input logic [1:0] action, input logic [1:0] target,
			input logic turn_on, input logic [1:0] requester);
		eaa_pkg::req_t r;
		r.action    = action;
		r.target    = target;
		r.turn_on   = turn_on;
		r.requester = requester;
		return r;
	endfunction

	task automatic issue(input eaa_pkg::req_t r);
		pending_q.push_back(r);
		n_issued++;
	endtask

	task automatic on_req(input logic [1:0] target, input logic [1:0] src);
		issue(mk_req(eaa_pkg::ACT_REQUEST, target, DIR_ON, src));
	endtask

	task automatic off_req(input logic [1:0] target, input logic [1:0] src);
		issue(mk_req(eaa_pkg::ACT_REQUEST, target, DIR_OFF, src));
	endtask

	// Ticks and releases ignore the other fields, so fill them with noise.
	task automatic tick(input int n);
		repeat (n)
			issue(mk_req(eaa_pkg::ACT_TICK, 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), 2'($urandom_range(0, 3))));
	endtask

	task automatic release_all();
		issue(mk_req(eaa_pkg::ACT_RELEASE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			2'($urandom_range(0, 3))));
	endtask

	function automatic logic [1:0] pick_target();
		if ($urandom_range(0, 7) == 0)
			return eaa_pkg::UNIT_NONE;
		return 2'($urandom_range(1, 3));
	endfunction

	function automatic logic [1:0] pick_src();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 40)
			return eaa_pkg::SRC_MANUAL;
		if (sel < 85)
			return eaa_pkg::SRC_TRIGGER;
		if (sel < 93)
			return eaa_pkg::SRC_NONE;
		return SRC_UNUSED;
	endfunction

	// Mostly short timeouts so that ticks reach them; now and then never or far away.
	function automatic logic [15:0] pick_timeout();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15)
			return '0;
		if (sel < 25)
			return 16'd1;
		if (sel < 85)
			return 16'($urandom_range(2, 12));
		return 16'($urandom_range(13, 65535));
	endfunction

	// One episode: an on-request, then a run of ticks mixed with contention and off-requests.
	// A tenth of the episodes is a single beat of pure noise.
	task automatic push_episode();
		int len;
		int sel;
		if ($urandom_range(0, 9) == 0) begin
			issue(7'($urandom_range(0, 127)));
		end else begin
			on_req(pick_target(), pick_src());
			len = $urandom_range(0, 14);
			repeat (len) begin
				sel = $urandom_range(0, 99);
				if (sel < 60)
					tick(1);
				else if (sel < 72)
					on_req(pick_target(), pick_src());
				else if (sel < 84)
					off_req(pick_target(), pick_src());
				else if (sel < 90)
					release_all();
				else if (sel < 95)
					issue(mk_req(ACT_UNUSED, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), pick_src()));
				else
					issue(7'($urandom_range(0, 127)));
			end
		end
	endtask

	// Wait until every issued beat has come back, then let the pipeline settle.
	task automatic drain();
		wait (n_checked >= n_issued);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_timeouts(input logic [15:0] spr, input logic [15:0] fan,
			input logic [15:0] lgt);
		write_reg(eaa_pkg::CFG_SPRINKLER_TIMEOUT, spr);
		write_reg(eaa_pkg::CFG_FAN_TIMEOUT, fan);
		write_reg(eaa_pkg::CFG_LIGHT_TIMEOUT, lgt);
	endtask

	// Request driver: bursts of random length with random gaps; hold a beat until taken.
	always @(negedge clk) begin : drive_requests
		logic send;
		eaa_pkg::req_t nxt;
		send = 1'b0;
		nxt  = drv_item;
		if (drv_valid && !req_took) begin
			send = 1'b1;
		end else if (arst_n) begin
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
			if (burst_left != 0) begin
				if (pending_q.size() != 0) begin
					nxt  = pending_q.pop_front();
					send = 1'b1;
					burst_left--;
				end
			end else begin
				gap_left--;
			end
		end
		drv_valid <= send;
		drv_item  <= nxt;
	end

	// Result receiver: stall pattern that is redrawn at random, plus long hold-offs on request.
	always @(negedge clk) begin : drive_ready
		logic rdy;
		if (hold_left == 0 && holds_served < hold_requests) begin
			hold_left = LONG_HOLD;
			holds_served++;
		end
		if (hold_left != 0) begin
			rdy = 1'b0;
			hold_left--;
		end else begin
			pattern_cnt++;
			if (pattern_cnt % 48 == 0)
				ready_mode = $urandom_range(0, 3);
			case (ready_mode)
			0:       rdy = 1'b1;
			1:       rdy = 1'($urandom_range(0, 1));
			2:       rdy = ($urandom_range(0, 3) == 0);
			default: rdy = ((pattern_cnt % 7) < 5);
			endcase
		end
		drv_ready <= rdy;
	end

	// Monitor: predict on every accepted request beat, check every accepted result beat,
	// track register writes, and watch for a stalled run.
	always @(posedge clk) begin : monitor
		eaa_pkg::res_t want;
		eaa_pkg::res_t got;
		logic busy;
		req_took <= drv_valid && (req_ch.ready === 1'b1);
		if (arst_n) begin
			busy = 1'b0;
			// predict first, so that a same-edge result still finds its expectation
			if (drv_valid && req_ch.ready === 1'b1) begin
				arbitrate(drv_item, want);
				expected_res_q.push_back(want);
				n_accepted++;
				n_expired += want.expired;
				n_granted += want.granted;
				busy = 1'b1;
			end
			if (res_ch.valid === 1'b1 && drv_ready) begin
				got = {res_ch.granted, res_ch.drive_sprinkler, res_ch.drive_fan,
					res_ch.drive_light, res_ch.owner_now, res_ch.expired};
				n_checked++;
				busy = 1'b1;
				if (expected_res_q.size() == 0) begin
					report($sformatf("result %0d arrived with nothing expected", n_checked));
				end else begin
					want = expected_res_q.pop_front();
					check_field("granted", want.granted, got.granted);
					check_field("drive_sprinkler", want.drive_sprinkler, got.drive_sprinkler);
					check_field("drive_fan", want.drive_fan, got.drive_fan);
					check_field("drive_light", want.drive_light, got.drive_light);
					check_field("owner_now", want.owner_now, got.owner_now);
					check_field("expired", want.expired, got.expired);
				end
			end
			if (cfg_valid && cfg_ch.ready === 1'b1) begin
				case (cfg_index)
				eaa_pkg::CFG_SPRINKLER_TIMEOUT: tmo_sprinkler = cfg_wdata;
				eaa_pkg::CFG_FAN_TIMEOUT:       tmo_fan       = cfg_wdata;
				eaa_pkg::CFG_LIGHT_TIMEOUT:     tmo_light     = cfg_wdata;
				default: ;   // index past the last register is dropped
				endcase
				n_cfg++;
				busy = 1'b1;
			end
			if (busy)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no beat accepted for %0d cycles, %0d of %0d results seen",
					IDLE_LIMIT, n_checked, n_issued);
				$display("tb_exclusive_actuator_arbiter_core failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int start;
		int k;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset timeouts are far away: a short run of ticks must leave each unit on.
		// Hold off the receiver meanwhile so the block backs up into its input.
		on_req(eaa_pkg::UNIT_FAN, eaa_pkg::SRC_MANUAL);
		tick(6);
		on_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_TRIGGER);  // busy: refused
		release_all();
		on_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_TRIGGER);
		tick(6);
		off_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_TRIGGER);
		on_req(eaa_pkg::UNIT_LIGHT, eaa_pkg::SRC_MANUAL);
		tick(6);
		release_all();
		hold_requests++;
		drain();

		// Directed: idle corner cases, refusals, takeover, never-expiring and short timeouts.
		set_timeouts(16'd1, 16'd3, 16'd0);
		tick(1);                                                 // idle tick does nothing
		off_req(eaa_pkg::UNIT_NONE, eaa_pkg::SRC_NONE);          // idle off naming nothing
		off_req(eaa_pkg::UNIT_NONE, eaa_pkg::SRC_MANUAL);
		off_req(eaa_pkg::UNIT_NONE, eaa_pkg::SRC_TRIGGER);       // not owner, not manual
		on_req(eaa_pkg::UNIT_NONE, eaa_pkg::SRC_TRIGGER);        // trigger for no unit
		on_req(eaa_pkg::UNIT_FAN, eaa_pkg::SRC_NONE);            // no source: refused
		on_req(eaa_pkg::UNIT_FAN, SRC_UNUSED);
		issue(mk_req(ACT_UNUSED, eaa_pkg::UNIT_FAN, DIR_ON, eaa_pkg::SRC_MANUAL));
		on_req(eaa_pkg::UNIT_FAN, eaa_pkg::SRC_TRIGGER);         // idle: granted to trigger
		on_req(eaa_pkg::UNIT_LIGHT, eaa_pkg::SRC_TRIGGER);       // busy: refused
		off_req(eaa_pkg::UNIT_LIGHT, eaa_pkg::SRC_MANUAL);       // wrong unit
		off_req(eaa_pkg::UNIT_FAN, eaa_pkg::SRC_NONE);           // wrong owner
		tick(2);
		on_req(eaa_pkg::UNIT_LIGHT, eaa_pkg::SRC_MANUAL);        // takeover restarts timer
		tick(3);                                                 // light never times out
		on_req(eaa_pkg::UNIT_NONE, eaa_pkg::SRC_MANUAL);         // manual on for nothing
		on_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_TRIGGER);
		tick(1);                                                 // one-tick timeout
		on_req(eaa_pkg::UNIT_FAN, eaa_pkg::SRC_MANUAL);
		tick(3);
		on_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_MANUAL);
		off_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_TRIGGER);  // cannot drop manual owner
		off_req(eaa_pkg::UNIT_SPRINKLER, eaa_pkg::SRC_MANUAL);
		on_req(eaa_pkg::UNIT_LIGHT, eaa_pkg::SRC_TRIGGER);
		off_req(eaa_pkg::UNIT_LIGHT, eaa_pkg::SRC_TRIGGER);
		on_req(eaa_pkg::UNIT_FAN, eaa_pkg::SRC_TRIGGER);
		release_all();
		drain();

		// Random episodes under a fresh set of timeouts per phase.
		for (k = 0; k < RAND_PHASES; k++) begin
			set_timeouts(pick_timeout(), pick_timeout(), pick_timeout());
			if (k == 1)
				write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
			start = n_issued;
			while (n_issued - start < RAND_ITEMS)
				push_episode();
			if (k == 2)
				hold_requests++;
			drain();
		end

		repeat (2 * DRAIN_CYCLES) @(negedge clk);
		if (expected_res_q.size() != 0)
			report($sformatf("%0d results never arrived", expected_res_q.size()));
		$display("covered %0d request beats, %0d result beats and %0d register writes",
			n_accepted, n_checked, n_cfg);
		$display("reset, directed and random timeouts under stalls, %0d grants, %0d auto-offs",
			n_granted, n_expired);
		if (n_errors == 0)
			$display("tb_exclusive_actuator_arbiter_core passed");
		else
			$display("tb_exclusive_actuator_arbiter_core failed");
		$finish;
	end

endmodule

// File: files.f
src/eaa_pkg.sv
src/eaa_ifs.sv
src/eaa_step.sv
src/exclusive_actuator_arbiter_core.sv
tb/tb_exclusive_actuator_arbiter_core.sv
